FILE: sv/assert_macros.svh
// assertion macros used by the tensor_element_to_bfloat16 rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is active
`define TEB_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define TEB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/teb_pkg.sv
// shared constants for the tensor element to bfloat16 converter
// no dependencies
package teb_pkg;

    localparam int RAW_W  = 32;
    localparam int BF16_W = 16;
    localparam int FMT_W  = 2;

    // source format codes
    localparam logic [FMT_W-1:0] FMT_BF16 = 2'd0;
    localparam logic [FMT_W-1:0] FMT_F32  = 2'd1;
    localparam logic [FMT_W-1:0] FMT_F16  = 2'd2;

    localparam logic [FMT_W-1:0] FMT_RESET = FMT_BF16;

    localparam logic [RAW_W-1:0] ROUND_BIAS    = 32'h0000_7FFF;
    // binary32 bias minus binary16 bias
    localparam logic [7:0]       EXP_BIAS_ADJ  = 8'd112;
    localparam logic [7:0]       EXP_ALL_ONES  = 8'hFF;
    localparam logic [4:0]       F16_EXP_ONES  = 5'h1F;

endpackage

FILE: sv/teb_stream_if.sv
// valid/ready channel interfaces for element requests and bfloat16 results
// depends on teb_pkg
interface teb_elem_if
    import teb_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_word;
    logic             last_in;

    modport source (output valid, output raw_word, output last_in, input ready);
    modport sink   (input valid, input raw_word, input last_in, output ready);
endinterface

interface teb_bf16_if
    import teb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BF16_W-1:0] bf16_value;
    logic              last_out;

    modport source (output valid, output bf16_value, output last_out, input ready);
    modport sink   (input valid, input bf16_value, input last_out, output ready);
endinterface

FILE: sv/teb_f16_widen.sv
// exact binary16 to binary32 widening, subnormals normalized
// depends on teb_pkg
module teb_f16_widen
    import teb_pkg::*;
(
    input  logic [15:0]      half,
    output logic [RAW_W-1:0] single
);

    logic       sign;
    logic [4:0] ex;
    logic [9:0] man;
    logic [3:0] msb;
    logic [3:0] shift;
    logic [9:0] man_norm;
    logic [7:0] sub_exp;

    assign sign = half[15];
    assign ex   = half[14:10];
    assign man  = half[9:0];

    // position of the leading one in a subnormal mantissa
    always_comb
    begin
        msb = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (man[i])
            begin
                msb = 4'(i);
            end
        end
    end

    assign shift    = 4'd10 - msb;
    assign man_norm = man << shift;
    // exponent 1 - shift, rebiased
    assign sub_exp  = EXP_BIAS_ADJ + 8'd1 - {4'd0, shift};

    always_comb
    begin
        if (ex == 5'd0)
        begin
            if (man == 10'd0)
            begin
                single = {sign, 31'd0};
            end
            else
            begin
                single = {sign, sub_exp, man_norm, 13'd0};
            end
        end
        else if (ex == F16_EXP_ONES)
        begin
            single = {sign, EXP_ALL_ONES, man, 13'd0};
        end
        else
        begin
            single = {sign, {3'd0, ex} + EXP_BIAS_ADJ, man, 13'd0};
        end
    end

endmodule

FILE: sv/teb_convert.sv
// format select and round-to-nearest-even of one element to bfloat16
// depends on teb_pkg and teb_f16_widen
module teb_convert
    import teb_pkg::*;
(
    input  logic [FMT_W-1:0]  source_format,
    input  logic [RAW_W-1:0]  raw_word,
    output logic [BF16_W-1:0] bf16_value
);

    logic [RAW_W-1:0] widened;
    logic [RAW_W-1:0] round_src;
    logic [RAW_W-1:0] round_sum;

    teb_f16_widen u_widen (
        .half   (raw_word[15:0]),
        .single (widened)
    );

    assign round_src = (source_format == FMT_F16) ? widened : raw_word;
    // bias plus kept lsb, wraps at 32 bits
    assign round_sum = round_src + ROUND_BIAS + {31'd0, round_src[16]};

    always_comb
    begin
        case (source_format)
            FMT_F32, FMT_F16: bf16_value = round_sum[31:16];
            default:          bf16_value = raw_word[15:0];
        endcase
    end

endmodule

FILE: sv/tensor_element_to_bfloat16.sv
// an accepted element request is held in the input register, converted, and
//   loaded into the result register that drives the result handshake
// throughput: one element per cycle unless result.ready stalls, set by the
//   input register feeding the conversion logic and the result register behind it
// reset: rst_n clears both stage valids and sets source_format to bfloat16
// depends on teb_pkg, teb_stream_if, teb_convert, assert_macros.svh
`include "assert_macros.svh"

module tensor_element_to_bfloat16
    import teb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [FMT_W-1:0] cfg_wr_data,
    teb_elem_if.sink         element,
    teb_bf16_if.source       result
);

    logic [FMT_W-1:0]  fmt_reg;
    logic              s1_valid_reg;
    logic [RAW_W-1:0]  s1_word_reg;
    logic              s1_last_reg;
    logic              out_valid_reg;
    logic [BF16_W-1:0] out_value_reg;
    logic              out_last_reg;

    logic              s1_ready;
    logic              out_ready;
    logic              s1_load;
    logic              out_load;
    logic [BF16_W-1:0] conv_value;

    assign out_ready = !out_valid_reg || result.ready;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign s1_load   = element.valid && s1_ready;
    assign out_load  = s1_valid_reg && out_ready;

    assign element.ready     = s1_ready;
    assign result.valid      = out_valid_reg;
    assign result.bf16_value = out_value_reg;
    assign result.last_out   = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg       <= FMT_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                fmt_reg <= cfg_wr_data;
            end
            if (s1_ready)
            begin
                s1_valid_reg <= element.valid;
            end
            if (out_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_word_reg <= element.raw_word;
            s1_last_reg <= element.last_in;
        end
        if (out_load)
        begin
            out_value_reg <= conv_value;
            out_last_reg  <= s1_last_reg;
        end
    end

    teb_convert u_convert (
        .source_format (fmt_reg),
        .raw_word      (s1_word_reg),
        .bf16_value    (conv_value)
    );

    `TEB_ASSERT_CLK(a_accept_fills_s1, clk, rst_n, s1_load |=> s1_valid_reg, "accepted request not in input stage")
    `TEB_ASSERT_CLK(a_s1_holds, clk, rst_n, (s1_valid_reg && !out_ready) |=> (s1_valid_reg && $stable(s1_word_reg)), "stalled input stage lost its request")
    `TEB_ASSERT_CLK(a_bf16_pass, clk, rst_n, (out_load && fmt_reg == FMT_BF16) |=> (out_value_reg == $past(s1_word_reg[15:0])), "bfloat16 element not passed through")
    `TEB_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> (!out_valid_reg && !s1_valid_reg), "valid set during reset")

endmodule

FILE: tb/sv/tb_tensor_element_to_bfloat16.sv
`timescale 1ns / 1ps
// self-checking testbench for tensor_element_to_bfloat16: element requests in,
// bfloat16 results checked in order against a local conversion predictor
// depends on teb_pkg, teb_stream_if and the tensor_element_to_bfloat16 rtl
module tb_tensor_element_to_bfloat16;
    import teb_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 12;
    localparam int DUT_LATENCY  = 2;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int ITEMS_PER_FORMAT = 90;

    // the register takes 2 bits; the spare code behaves like bfloat16
    localparam logic [FMT_W-1:0] FMT_SPARE = 2'd3;

    typedef struct packed {
        logic [BF16_W-1:0] value;
        logic              last;
    } bf16_result_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [FMT_W-1:0] cfg_wr_data;

    teb_elem_if elem_ch ();
    teb_bf16_if res_ch ();

    tensor_element_to_bfloat16 dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .element     (elem_ch),
        .result      (res_ch)
    );

    bf16_result_t     pending_bf16_q[$];
    bf16_result_t     oldest_bf16;
    logic [FMT_W-1:0] source_fmt;
    int               send_idle_pct;
    int               stall_pct;
    int               error_count;
    int               cycle_count;

    always #CLK_HALF clk = ~clk;

    // ---------------------------------------------------------------
    // conversion predictor
    // ---------------------------------------------------------------
    function automatic logic [BF16_W-1:0] round_to_bf16(input logic [RAW_W-1:0] bits);
        logic [RAW_W-1:0] sum;
        // nearest even: bias plus the lowest kept bit, carry out of 32 bits is lost
        sum = bits + ROUND_BIAS + {31'd0, bits[16]};
        return sum[31:16];
    endfunction

    function automatic logic [RAW_W-1:0] widen_half(input logic [15:0] h);
        logic [4:0]  ex;
        logic [10:0] man;
        logic [7:0]  fexp;
        int          shift;
        ex    = h[14:10];
        man   = {1'b0, h[9:0]};
        shift = 0;
        if (ex == 5'd0)
        begin
            if (man == 11'd0)
                return {h[15], 31'd0};
            // subnormal: normalize until the hidden bit shows up
            while (!man[10])
            begin
                man = man << 1;
                shift++;
            end
            fexp = EXP_BIAS_ADJ + 8'd1 - 8'(shift);
            return {h[15], fexp, man[9:0], 13'd0};
        end
        if (ex == F16_EXP_ONES)
            return {h[15], EXP_ALL_ONES, man[9:0], 13'd0};
        fexp = EXP_BIAS_ADJ + {3'd0, ex};
        return {h[15], fexp, man[9:0], 13'd0};
    endfunction

    function automatic logic [BF16_W-1:0] convert_to_bf16(input logic [FMT_W-1:0] fmt,
                                                          input logic [RAW_W-1:0] raw);
        case (fmt)
            FMT_F32: return round_to_bf16(raw);
            FMT_F16: return round_to_bf16(widen_half(raw[15:0]));
            default: return raw[15:0];
        endcase
    endfunction

    // ---------------------------------------------------------------
    // request driver and register writes, entered at a falling edge
    // ---------------------------------------------------------------
    task automatic send_element(input logic [RAW_W-1:0] raw, input logic last);
        bf16_result_t expected;
        while ($urandom_range(99) < send_idle_pct)
        begin
            elem_ch.valid = 1'b0;
            @(negedge clk);
        end
        elem_ch.valid    = 1'b1;
        elem_ch.raw_word = raw;
        elem_ch.last_in  = last;
        @(posedge clk);
        while (!elem_ch.ready)
            @(posedge clk);
        expected.value = convert_to_bf16(source_fmt, raw);
        expected.last  = last;
        pending_bf16_q.insert(pending_bf16_q.size(), expected);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pending_bf16_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_source_format(input logic [FMT_W-1:0] fmt);
        elem_ch.valid = 1'b0;
        wait_drained();
        repeat (DUT_LATENCY + 2) @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = fmt;
        @(negedge clk);
        cfg_wr_en  = 1'b0;
        source_fmt = fmt;
    endtask

    function automatic logic [RAW_W-1:0] pick_raw_word();
        logic [RAW_W-1:0] w;
        int               kind;
        w    = $urandom;
        kind = $urandom_range(0, 7);
        case (kind)
            4:
            begin
                // exponent extremes for both wide and half layouts
                w[30:23] = $urandom_range(0, 1) ? EXP_ALL_ONES : 8'h00;
                w[14:10] = $urandom_range(0, 1) ? F16_EXP_ONES : 5'h00;
            end
            5:
            begin
                // rounding ties and near-ties in the dropped half
                case ($urandom_range(0, 3))
                    0: w[15:0] = 16'h8000;
                    1: w[15:0] = 16'h7FFF;
                    2: w[15:0] = 16'h0000;
                    default: w[15:0] = 16'hFFFF;
                endcase
            end
            6:
            begin
                // half subnormals with varied leading-zero counts
                w[14:10] = 5'h00;
                w[9:0]   = w[9:0] >> $urandom_range(0, 9);
            end
            7: w[31:16] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: ;
        endcase
        return w;
    endfunction

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    task automatic test_reset_format();
        // no write yet: the register must come out of reset as bfloat16
        source_fmt = FMT_RESET;
        send_element(32'hFFFF_3F80, 1'b0);
        send_element(32'h0000_0000, 1'b0);
        send_element(32'hA5A5_FFFF, 1'b1);
    endtask

    task automatic test_binary32_rounding();
        set_source_format(FMT_F32);
        send_element(32'h0000_0000, 1'b0);
        send_element(32'hFFFF_FFFF, 1'b0);
        send_element(32'hFFFF_8000, 1'b0);   // carry wraps to zero
        send_element(32'h7F7F_FFFF, 1'b0);   // max finite rounds into infinity
        send_element(32'h3F80_8000, 1'b0);   // tie, kept bit even
        send_element(32'h3F81_8000, 1'b0);   // tie, kept bit odd
        send_element(32'h7F80_0001, 1'b0);   // small nan rounds into infinity
        send_element(32'h7FFF_FFFF, 1'b0);   // nan carries across the sign
        send_element(32'hFF80_0000, 1'b0);
        send_element(32'h8000_0000, 1'b1);
    endtask

    task automatic test_binary16_widening();
        set_source_format(FMT_F16);
        send_element(32'h0000_0000, 1'b0);
        send_element(32'hFFFF_8000, 1'b0);   // negative zero, upper bits ignored
        send_element(32'h0000_0001, 1'b0);   // smallest subnormal
        send_element(32'h0000_83FF, 1'b0);   // largest-magnitude negative subnormal
        send_element(32'h0000_0400, 1'b0);
        send_element(32'h0000_7BFF, 1'b0);
        send_element(32'h0000_7C00, 1'b0);
        send_element(32'h0000_FC00, 1'b0);
        send_element(32'h1234_7FFF, 1'b0);   // nan with full mantissa
        send_element(32'h0000_3C00, 1'b1);
    endtask

    task automatic test_spare_format();
        set_source_format(FMT_SPARE);
        send_element(32'hDEAD_BEEF, 1'b0);
        send_element(32'h0000_FFFF, 1'b1);
    endtask

    task automatic test_random_stream();
        int phase;
        int fi;
        int n;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 60;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 60;
                end
                default:
                begin
                    send_idle_pct = 15;
                    stall_pct     = 15;
                end
            endcase
            for (fi = 0; fi < 4; fi++)
            begin
                set_source_format(FMT_W'((fi + phase) % 4));
                for (n = 0; n < ITEMS_PER_FORMAT; n++)
                    send_element(pick_raw_word(), $urandom_range(0, 7) == 0);
            end
        end
    endtask

    task automatic test_drain_pause();
        int n;
        send_idle_pct = 0;
        stall_pct     = 60;
        set_source_format(FMT_F16);
        for (n = 0; n < 12; n++)
            send_element(pick_raw_word(), 1'($urandom_range(0, 1)));
        // hold requests back until every result is out, then resume
        elem_ch.valid = 1'b0;
        wait_drained();
        @(negedge clk);
        for (n = 0; n < 12; n++)
            send_element(pick_raw_word(), 1'($urandom_range(0, 1)));
        stall_pct = 0;
    endtask

    // ---------------------------------------------------------------
    // result checker
    // ---------------------------------------------------------------
    always @(negedge clk)
        res_ch.ready = ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_bf16_q.size() == 0)
            begin
                $error("unexpected result: bf16_value %h last_out %b",
                       res_ch.bf16_value, res_ch.last_out);
                error_count++;
            end
            else
            begin
                oldest_bf16 = pending_bf16_q.pop_front();
                if (res_ch.bf16_value !== oldest_bf16.value)
                begin
                    $error("bf16_value: expected %h, got %h",
                           oldest_bf16.value, res_ch.bf16_value);
                    error_count++;
                end
                if (res_ch.last_out !== oldest_bf16.last)
                begin
                    $error("last_out: expected %b, got %b",
                           oldest_bf16.last, res_ch.last_out);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tensor_element_to_bfloat16 verification failed");
            $finish;
        end
    end

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = FMT_BF16;
        elem_ch.valid    = 1'b0;
        elem_ch.raw_word = '0;
        elem_ch.last_in  = 1'b0;
        res_ch.ready     = 1'b0;
        source_fmt       = FMT_RESET;
        send_idle_pct    = 0;
        stall_pct        = 0;
        error_count      = 0;
        cycle_count      = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_format();
        test_binary32_rounding();
        test_binary16_widening();
        test_spare_format();
        test_random_stream();
        test_drain_pause();
        set_source_format(FMT_BF16);

        elem_ch.valid = 1'b0;
        wait_drained();
        repeat (DUT_LATENCY + 8) @(negedge clk);
        if (error_count == 0)
            $display("tensor_element_to_bfloat16 verification clean");
        else
            $display("tensor_element_to_bfloat16 verification failed");
        $finish;
    end

endmodule
